// ===== sv/ohf_pkg.sv =====
// Shared constants, action codes and the ring index helper for the overwrite history FIFO.
// Depends on nothing; used by overwrite_history_fifo.
`timescale 1ns / 1ps

package ohf_pkg;

   // Store geometry
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 64;
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // Port field widths
   localparam int ACT_BITS   = 3;
   localparam int MSG_BITS   = 64;
   localparam int FETCH_BITS = 5;
   localparam int OCC_BITS   = 5;
   localparam int REQ_DATA_BITS = 72;   // message_in + fetch_count, padded to bytes
   localparam int RSP_DATA_BITS = 72;   // message_out + overwrote_oldest + occupancy, padded
   localparam int CMP_BITS   = (CNT_BITS > FETCH_BITS) ? CNT_BITS : FETCH_BITS;

   // Action codes
   localparam logic [ACT_BITS-1:0] ACT_ENQUEUE     = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_DEQUEUE     = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_PEEK_OLDEST = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_PEEK_NEWEST = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_FETCH       = 3'd4;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef logic [PTR_BITS-1:0] ptr_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // Ring slot at base + off, wrapped once (both operands below DEPTH)
   function automatic ptr_type slot_of(input ptr_type base, input ptr_type off);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_BITS + 1)'(DEPTH)) begin
         sum = sum - (PTR_BITS + 1)'(DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

// ===== sv/overwrite_history_fifo.sv =====
// Overwrite history FIFO: ring of message words in one synchronous memory, with
// oldest pointer and fill count in flops. Depends on ohf_pkg.
//
//   channel | ports          | payload
//   --------+----------------+-------------------------------------------------------
//   input   | req_t*         | tuser: action; tdata: message_in, fetch_count
//   result  | rsp_t*         | tuser: status; tdata: message_out, overwrote_oldest,
//           |                | occupancy; tlast: last_result
//
// An item is accepted only when idle, its memory read or write issued in that cycle, and its
// first result loaded into the output register in the execute state once that register is free;
// no new item is taken until its last result is loaded. Fetch recent streams one word per cycle
// while the output is not stalled, set by the single memory read port. Reset clears state,
// pointer, count and output valid; the memory is not cleared. A stalled result holds the output
// register; one further item may be accepted meanwhile and waits for the register to free.
`timescale 1ns / 1ps

module overwrite_history_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ohf_pkg::ACT_BITS-1:0]        req_tuser,   // [2:0] action
   input  logic [ohf_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [63:0] message_in,
                                                            // [68:64] fetch_count, [71:69] 0
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,   // [0] status
   output logic [ohf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // [63:0] message_out,
                                                            // [64] overwrote_oldest,
                                                            // [69:65] occupancy, [71:70] 0
   output logic                                rsp_tlast    // last_result
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;

   // Control and state registers
   logic [1:0]       state_ff, state_in;
   ohf_pkg::ptr_type ptr_ff, ptr_in;
   ohf_pkg::cnt_type count_ff, count_in;
   ohf_pkg::cnt_type rem_ff, rem_in;
   ohf_pkg::ptr_type rd_off_ff, rd_off_in;
   logic             status_ff, status_in;
   logic             use_mem_ff, use_mem_in;
   logic             over_ff, over_in;

   // Output register
   logic                              rsp_valid_ff;
   logic                              rsp_status_ff;
   logic [ohf_pkg::MSG_BITS-1:0]      rsp_msg_ff;
   logic                              rsp_over_ff;
   logic [ohf_pkg::OCC_BITS-1:0]      rsp_occ_ff;
   logic                              rsp_last_ff;

   // Memory
   logic [ohf_pkg::WORD_BITS-1:0] mem [ohf_pkg::DEPTH];
   logic [ohf_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                          mem_we, mem_re;
   ohf_pkg::ptr_type              waddr, raddr;

   logic [ohf_pkg::ACT_BITS-1:0]   act;
   logic [ohf_pkg::FETCH_BITS-1:0] fetch_count;
   logic                           accept;
   logic                           out_free;
   logic                           emit;
   logic                           full;
   logic                           empty;

   assign act         = req_tuser;
   assign fetch_count = req_tdata[68:64];
   assign req_tready  = (state_ff == S_IDLE) && !reset;
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign emit        = (state_ff == S_EXEC) && out_free;
   assign full        = (count_ff == ohf_pkg::CNT_BITS'(ohf_pkg::DEPTH));
   assign empty       = (count_ff == '0);

   // Decode the accepted item, issue its memory access, and step the fetch stream
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      rd_off_in  = rd_off_ff;
      status_in  = status_ff;
      use_mem_in = use_mem_ff;
      over_in    = over_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      waddr      = ptr_ff;
      raddr      = ptr_ff;

      if (accept) begin
         state_in   = S_EXEC;
         rem_in     = ohf_pkg::CNT_BITS'(1);
         status_in  = ohf_pkg::STATUS_OK;
         use_mem_in = 1'b0;
         over_in    = 1'b0;
         case (act)
            ohf_pkg::ACT_ENQUEUE: begin
               mem_we = 1'b1;
               if (full) begin
                  // drop the oldest: its slot takes the new word
                  waddr   = ptr_ff;
                  ptr_in  = ohf_pkg::slot_of(ptr_ff, ohf_pkg::PTR_BITS'(1));
                  over_in = 1'b1;
               end else begin
                  waddr    = ohf_pkg::slot_of(ptr_ff, ohf_pkg::PTR_BITS'(count_ff));
                  count_in = count_ff + ohf_pkg::CNT_BITS'(1);
               end
            end
            ohf_pkg::ACT_DEQUEUE: begin
               if (empty) begin
                  status_in = ohf_pkg::STATUS_ERROR;
               end else begin
                  mem_re     = 1'b1;
                  raddr      = ptr_ff;
                  use_mem_in = 1'b1;
                  ptr_in     = ohf_pkg::slot_of(ptr_ff, ohf_pkg::PTR_BITS'(1));
                  count_in   = count_ff - ohf_pkg::CNT_BITS'(1);
               end
            end
            ohf_pkg::ACT_PEEK_OLDEST: begin
               if (empty) begin
                  status_in = ohf_pkg::STATUS_ERROR;
               end else begin
                  mem_re     = 1'b1;
                  raddr      = ptr_ff;
                  use_mem_in = 1'b1;
               end
            end
            ohf_pkg::ACT_PEEK_NEWEST: begin
               if (empty) begin
                  status_in = ohf_pkg::STATUS_ERROR;
               end else begin
                  mem_re     = 1'b1;
                  raddr      = ohf_pkg::slot_of(ptr_ff,
                                  ohf_pkg::PTR_BITS'(count_ff - ohf_pkg::CNT_BITS'(1)));
                  use_mem_in = 1'b1;
               end
            end
            ohf_pkg::ACT_FETCH: begin
               if (ohf_pkg::CMP_BITS'(fetch_count) > ohf_pkg::CMP_BITS'(count_ff)) begin
                  status_in = ohf_pkg::STATUS_ERROR;
               end else if (fetch_count != '0) begin
                  // newest first: start at offset count-1 and walk down
                  rd_off_in  = ohf_pkg::PTR_BITS'(count_ff - ohf_pkg::CNT_BITS'(1));
                  mem_re     = 1'b1;
                  raddr      = ohf_pkg::slot_of(ptr_ff, rd_off_in);
                  use_mem_in = 1'b1;
                  rem_in     = ohf_pkg::CNT_BITS'(fetch_count);
               end
            end
            default: begin
               status_in = ohf_pkg::STATUS_ERROR;
            end
         endcase
      end else if (emit) begin
         if (rem_ff > ohf_pkg::CNT_BITS'(1)) begin
            // fetch the next older word while this one leaves
            rem_in    = rem_ff - ohf_pkg::CNT_BITS'(1);
            rd_off_in = rd_off_ff - ohf_pkg::PTR_BITS'(1);
            mem_re    = 1'b1;
            raddr     = ohf_pkg::slot_of(ptr_ff, rd_off_in);
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   // Word store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= req_tdata[ohf_pkg::WORD_BITS-1:0];
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
      end
   end

   // Per-item registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      rd_off_ff  <= rd_off_in;
      status_ff  <= status_in;
      use_mem_ff <= use_mem_in;
      over_ff    <= over_in;
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= status_ff;
         rsp_msg_ff    <= use_mem_ff ? ohf_pkg::MSG_BITS'(rd_data_ff) : '0;
         rsp_over_ff   <= over_ff;
         rsp_occ_ff    <= ohf_pkg::OCC_BITS'(count_ff);
         rsp_last_ff   <= (rem_ff <= ohf_pkg::CNT_BITS'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_occ_ff, rsp_over_ff, rsp_msg_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Fill count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ohf_pkg::CNT_BITS'(ohf_pkg::DEPTH))
      else $error("fill count above depth");

   // An overwrite is only reported with a full store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_over_ff) |-> (rsp_occ_ff == ohf_pkg::OCC_BITS'(ohf_pkg::DEPTH)))
      else $error("overwrite flagged without full store");

   // An error result always ends its item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ohf_pkg::STATUS_ERROR)) |-> rsp_last_ff)
      else $error("error result not marked last");

   // A new result is only loaded from the execute state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_EXEC))
      else $error("result loaded outside execute state");

endmodule
